// ----- rtl/twbc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package twbc_pkg;

   // Store geometry.
   localparam int MAX_ROWS = 64;
   localparam int MAX_COLS = 256;
   localparam int DEPTH    = MAX_ROWS * MAX_COLS;
   localparam int ROW_W    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int COL_W    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // Signed working width for box coordinates: holds -512 .. 1022 and MAX_COLS.
   localparam int COORD_W  = 12;

   // Field widths.
   localparam int ACTION_W = 2;
   localparam int ANCHOR_W = 10;
   localparam int SIZE_W   = 9;
   localparam int CROW_W   = 7;
   localparam int CCOL_W   = 9;
   localparam int GLYPH_W  = 3;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 9;
   localparam int SROWS_W  = 7;
   localparam int SCOLS_W  = 9;

   // Actions.
   localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_DRAW  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_READ  = 2'd2;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_ROWS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_COLS = 1'd1;

   localparam logic [SROWS_W-1:0] SCREEN_ROWS_RESET = 7'd64;
   localparam logic [SCOLS_W-1:0] SCREEN_COLS_RESET = 9'd256;

   // Glyph codes.
   localparam logic [GLYPH_W-1:0] G_EMPTY = 3'd0;
   localparam logic [GLYPH_W-1:0] G_TL    = 3'd1;
   localparam logic [GLYPH_W-1:0] G_TR    = 3'd2;
   localparam logic [GLYPH_W-1:0] G_BL    = 3'd3;
   localparam logic [GLYPH_W-1:0] G_BR    = 3'd4;
   localparam logic [GLYPH_W-1:0] G_HOR   = 3'd5;
   localparam logic [GLYPH_W-1:0] G_VER   = 3'd6;
   localparam logic [GLYPH_W-1:0] G_BLANK = 3'd7;

   // One write and one read of the glyph store per cycle.
   typedef struct packed {
      logic                wr_en;
      logic [ADDR_W-1:0]   wr_addr;
      logic [GLYPH_W-1:0]  wr_data;
      logic [ADDR_W-1:0]   rd_addr;
   } store_req_type;

   // Zero-based row and column to a linear store address.
   function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                   input logic [COL_W-1:0] col);
      cell_addr = ADDR_W'(row) * ADDR_W'(MAX_COLS) + ADDR_W'(col);
   endfunction

endpackage

`default_nettype wire

// ----- rtl/twbc_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface twbc_req_if;
   logic                                  valid;
   logic                                  ready;
   logic        [twbc_pkg::ACTION_W-1:0]  action;
   logic signed [twbc_pkg::ANCHOR_W-1:0]  box_row;
   logic signed [twbc_pkg::ANCHOR_W-1:0]  box_col;
   logic        [twbc_pkg::SIZE_W-1:0]    box_width;
   logic        [twbc_pkg::SIZE_W-1:0]    box_height;
   logic        [twbc_pkg::CROW_W-1:0]    cell_row;
   logic        [twbc_pkg::CCOL_W-1:0]    cell_col;

   modport source (output valid, action, box_row, box_col, box_width, box_height,
                   cell_row, cell_col, input ready);
   modport sink   (input valid, action, box_row, box_col, box_width, box_height,
                   cell_row, cell_col, output ready);
endinterface

interface twbc_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [twbc_pkg::GLYPH_W-1:0]   glyph_code;

   modport source (output valid, glyph_code, input ready);
   modport sink   (input valid, glyph_code, output ready);
endinterface

interface twbc_csr_if;
   logic                              valid;
   logic                              ready;
   logic [twbc_pkg::CSR_IDX_W-1:0]    index;
   logic [twbc_pkg::CSR_DATA_W-1:0]   write_data;

   modport source (output valid, index, write_data, input ready);
   modport sink   (input valid, index, write_data, output ready);
endinterface

`default_nettype wire

// ----- rtl/twbc_store.sv -----
`timescale 1ns / 1ps
`default_nettype none

module twbc_store (
   input  wire logic                          clock,
   input  wire twbc_pkg::store_req_type       store_req,
   output logic [twbc_pkg::GLYPH_W-1:0]       rd_data
);

   logic [twbc_pkg::GLYPH_W-1:0] mem [twbc_pkg::DEPTH];
   logic [twbc_pkg::GLYPH_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (store_req.wr_en) begin
         mem[store_req.wr_addr] <= store_req.wr_data;
      end
      rd_data_ff <= mem[store_req.rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/twbc_walker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module twbc_walker (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic [twbc_pkg::SROWS_W-1:0]      screen_rows,
   input  wire logic [twbc_pkg::SCOLS_W-1:0]      screen_cols,
   twbc_req_if.sink                               req,
   twbc_rsp_if.source                             rsp,
   output twbc_pkg::store_req_type                store_req,
   input  wire logic [twbc_pkg::GLYPH_W-1:0]      rd_data
);

   localparam int CW = twbc_pkg::COORD_W;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_CLIP, ST_CELL_RD, ST_CELL_WR,
      ST_READ_RD, ST_READ_DATA, ST_RESP
   } state_type;

   state_type                          state_ff;
   logic [twbc_pkg::ADDR_W-1:0]        clr_addr_ff;
   logic signed [CW-1:0]               top_ff, left_ff, bottom_ff, right_ff;
   logic signed [CW-1:0]               r_ff, c_ff, r1_ff, c0_ff, c1_ff;
   logic [twbc_pkg::ADDR_W-1:0]        rd_addr_ff;
   logic                               rd_ok_ff;
   logic                               rsp_valid_ff;
   logic [twbc_pkg::GLYPH_W-1:0]       glyph_ff;

   logic signed [CW-1:0] req_top, req_left, req_bottom, req_right;
   logic signed [CW-1:0] rmax, cmax, clip_r0, clip_r1, clip_c0, clip_c1;
   logic signed [CW-1:0] r_m1, c_m1, crow_m1, ccol_m1, crow_x, ccol_x;
   logic [twbc_pkg::ADDR_W-1:0] walk_addr;
   logic [twbc_pkg::GLYPH_W-1:0] cell_glyph;
   logic                  req_rd_ok;

   // Box corners, registered at acceptance.
   assign req_top    = CW'(req.box_row);
   assign req_left   = CW'(req.box_col);
   assign req_bottom = req_top + $signed({{(CW - twbc_pkg::SIZE_W){1'b0}}, req.box_height});
   assign req_right  = req_left + $signed({{(CW - twbc_pkg::SIZE_W){1'b0}}, req.box_width});

   // Read request range check and address.
   assign crow_x    = $signed({{(CW - twbc_pkg::CROW_W){1'b0}}, req.cell_row});
   assign ccol_x    = $signed({{(CW - twbc_pkg::CCOL_W){1'b0}}, req.cell_col});
   assign crow_m1   = crow_x - CW'(1);
   assign ccol_m1   = ccol_x - CW'(1);
   assign req_rd_ok = (crow_x >= CW'(1)) && (crow_x <= CW'(twbc_pkg::MAX_ROWS)) &&
                      (ccol_x >= CW'(1)) && (ccol_x <= CW'(twbc_pkg::MAX_COLS));

   // Visible screen, limited to the store, and the box clipped to that screen.
   always_comb begin
      rmax = $signed({{(CW - twbc_pkg::SROWS_W){1'b0}}, screen_rows});
      if (rmax > CW'(twbc_pkg::MAX_ROWS)) begin
         rmax = CW'(twbc_pkg::MAX_ROWS);
      end
      cmax = $signed({{(CW - twbc_pkg::SCOLS_W){1'b0}}, screen_cols});
      if (cmax > CW'(twbc_pkg::MAX_COLS)) begin
         cmax = CW'(twbc_pkg::MAX_COLS);
      end
      clip_r0 = (top_ff < CW'(1)) ? CW'(1) : top_ff;
      clip_r1 = (bottom_ff > rmax) ? rmax : bottom_ff;
      clip_c0 = (left_ff < CW'(1)) ? CW'(1) : left_ff;
      clip_c1 = (right_ff > cmax) ? cmax : right_ff;
   end

   // Glyph for the current cell; the top edge wins over the bottom edge and
   // the left border over the right one when they coincide.
   always_comb begin
      if (r_ff == top_ff) begin
         cell_glyph = (c_ff == left_ff) ? twbc_pkg::G_TL :
                      (c_ff == right_ff) ? twbc_pkg::G_TR : twbc_pkg::G_HOR;
      end else if (r_ff == bottom_ff) begin
         cell_glyph = (c_ff == left_ff) ? twbc_pkg::G_BL :
                      (c_ff == right_ff) ? twbc_pkg::G_BR : twbc_pkg::G_HOR;
      end else if ((c_ff == left_ff) || (c_ff == right_ff)) begin
         cell_glyph = twbc_pkg::G_VER;
      end else begin
         cell_glyph = twbc_pkg::G_BLANK;
      end
   end

   assign r_m1      = r_ff - CW'(1);
   assign c_m1      = c_ff - CW'(1);
   assign walk_addr = twbc_pkg::cell_addr(r_m1[twbc_pkg::ROW_W-1:0],
                                          c_m1[twbc_pkg::COL_W-1:0]);

   // Store access for the current state.
   always_comb begin
      store_req.wr_en   = 1'b0;
      store_req.wr_addr = walk_addr;
      store_req.wr_data = cell_glyph;
      store_req.rd_addr = walk_addr;
      unique case (state_ff)
         ST_CLEAR: begin
            store_req.wr_en   = 1'b1;
            store_req.wr_addr = clr_addr_ff;
            store_req.wr_data = twbc_pkg::G_EMPTY;
         end
         ST_CELL_WR: begin
            store_req.wr_en = (rd_data == twbc_pkg::G_EMPTY);
         end
         ST_READ_RD: begin
            store_req.rd_addr = rd_addr_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_CLEAR: begin
               clr_addr_ff <= clr_addr_ff + twbc_pkg::ADDR_W'(1);
               if (clr_addr_ff == twbc_pkg::ADDR_W'(twbc_pkg::DEPTH - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req.valid) begin
                  top_ff     <= req_top;
                  left_ff    <= req_left;
                  bottom_ff  <= req_bottom;
                  right_ff   <= req_right;
                  rd_ok_ff   <= req_rd_ok;
                  rd_addr_ff <= twbc_pkg::cell_addr(crow_m1[twbc_pkg::ROW_W-1:0],
                                                    ccol_m1[twbc_pkg::COL_W-1:0]);
                  unique case (req.action)
                     twbc_pkg::ACT_CLEAR: begin
                        clr_addr_ff <= '0;
                        state_ff    <= ST_CLEAR;
                     end
                     twbc_pkg::ACT_DRAW: state_ff <= ST_CLIP;
                     twbc_pkg::ACT_READ: state_ff <= ST_READ_RD;
                     default:            state_ff <= ST_IDLE;
                  endcase
               end
            end
            ST_CLIP: begin
               r_ff  <= clip_r0;
               c_ff  <= clip_c0;
               r1_ff <= clip_r1;
               c0_ff <= clip_c0;
               c1_ff <= clip_c1;
               if ((clip_r0 > clip_r1) || (clip_c0 > clip_c1)) begin
                  state_ff <= ST_IDLE;
               end else begin
                  state_ff <= ST_CELL_RD;
               end
            end
            ST_CELL_RD: begin
               state_ff <= ST_CELL_WR;
            end
            ST_CELL_WR: begin
               if (c_ff == c1_ff) begin
                  if (r_ff == r1_ff) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     r_ff     <= r_ff + CW'(1);
                     c_ff     <= c0_ff;
                     state_ff <= ST_CELL_RD;
                  end
               end else begin
                  c_ff     <= c_ff + CW'(1);
                  state_ff <= ST_CELL_RD;
               end
            end
            ST_READ_RD: begin
               state_ff <= ST_READ_DATA;
            end
            ST_READ_DATA: begin
               glyph_ff     <= rd_ok_ff ? rd_data : twbc_pkg::G_EMPTY;
               rsp_valid_ff <= 1'b1;
               state_ff     <= ST_RESP;
            end
            ST_RESP: begin
               if (rsp.ready) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req.ready      = (state_ff == ST_IDLE);
   assign rsp.valid      = rsp_valid_ff;
   assign rsp.glyph_code = glyph_ff;

endmodule

`default_nettype wire

// ----- rtl/text_window_border_compositor.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Character-cell window compositor with a 64 x 256 glyph store.
// The request channel carries one transaction per command: clear the store,
// draw a box, or read one cell. Only a read produces a response transaction,
// which carries the 3-bit glyph code of the addressed cell.
// The configuration channel sets the visible screen size and is always ready;
// write it only while the block is idle. Writes do not touch the store.
// A clear writes the empty glyph to every store entry in turn.
// A draw first clips the box to the visible screen, then visits every visible
// cell of the box in turn as a read and a write that happens only if the
// cell is still empty. A box clipped away entirely leaves the store untouched.
// A read addresses the store, registers the glyph and then raises response
// valid; a cell outside the store reads as empty.
// The request channel is ready only while the sequencer is idle, so commands
// are processed one at a time.
// After reset the block runs a clearing pass over the store before it accepts
// the first request; the screen returns to 64 x 256.
// When the receiver stalls a response, the response is held stable and no new
// request is accepted until it has been taken.

module text_window_border_compositor (
   input  wire logic     clock,
   input  wire logic     reset,
   twbc_req_if.sink      req_port,
   twbc_rsp_if.source    rsp_port,
   twbc_csr_if.sink      csr_port
);

   logic [twbc_pkg::SROWS_W-1:0] screen_rows_ff;
   logic [twbc_pkg::SCOLS_W-1:0] screen_cols_ff;
   twbc_pkg::store_req_type      store_req;
   logic [twbc_pkg::GLYPH_W-1:0] rd_data;

   // Configuration registers take a write in any cycle.
   assign csr_port.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_rows_ff <= twbc_pkg::SCREEN_ROWS_RESET;
         screen_cols_ff <= twbc_pkg::SCREEN_COLS_RESET;
      end else if (csr_port.valid) begin
         unique case (csr_port.index)
            twbc_pkg::CSR_SCREEN_ROWS:
               screen_rows_ff <= csr_port.write_data[twbc_pkg::SROWS_W-1:0];
            twbc_pkg::CSR_SCREEN_COLS:
               screen_cols_ff <= csr_port.write_data[twbc_pkg::SCOLS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // The sequencer walks the box and owns the request and response channels.
   twbc_walker u_walker (
      .clock       (clock),
      .reset       (reset),
      .screen_rows (screen_rows_ff),
      .screen_cols (screen_cols_ff),
      .req         (req_port),
      .rsp         (rsp_port),
      .store_req   (store_req),
      .rd_data     (rd_data)
   );

   // Glyph store with one write port and one registered read port.
   twbc_store u_store (
      .clock     (clock),
      .store_req (store_req),
      .rd_data   (rd_data)
   );

endmodule

`default_nettype wire
